FILE: design/bllz_pkg.sv
package bllz_pkg;

	localparam int DICT_W = 17;
	localparam int TOT_W = 32;
	localparam logic [DICT_W-1:0] DICT_RESET = 17'h10000;
	localparam logic [DICT_W-1:0] ENT_MAX = {DICT_W{1'b1}};
	localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

	typedef struct packed {
		logic start;
		logic seed;
		logic sample;
	} walk_req_t;

	typedef struct packed {
		logic idle;
		logic done;
		logic have;
		logic pred;
	} walk_rsp_t;

	typedef struct packed {
		logic load;
		logic scored;
		logic hit;
	} score_upd_t;

	function automatic logic [TOT_W-1:0] tot_inc(input logic [TOT_W-1:0] v);
		return (v == TOT_MAX) ? v : v + TOT_W'(1);
	endfunction

endpackage

FILE: design/bllz_if.sv
interface bllz_smp_if;
	logic valid;
	logic ready;
	logic sample_bit;

	modport source (output valid, output sample_bit, input ready);
	modport sink (input valid, input sample_bit, output ready);
endinterface

interface bllz_res_if import bllz_pkg::*; ();
	logic valid;
	logic ready;
	logic scored;
	logic have_prediction;
	logic predicted_bit;
	logic hit;
	logic [TOT_W-1:0] correct_total;
	logic [TOT_W-1:0] longest_run;
	logic [TOT_W-1:0] scored_total;

	modport source (output valid, output scored, output have_prediction, output predicted_bit,
		output hit, output correct_total, output longest_run, output scored_total,
		input ready);
	modport sink (input valid, input scored, input have_prediction, input predicted_bit,
		input hit, input correct_total, input longest_run, input scored_total,
		output ready);
endinterface

interface bllz_cfg_if import bllz_pkg::*; ();
	logic valid;
	logic ready;
	logic [DICT_W-1:0] dict_limit;

	modport source (output valid, output dict_limit, input ready);
	modport sink (input valid, input dict_limit, output ready);
endinterface

FILE: design/bllz_count_ram.sv
module bllz_count_ram #(
	parameter int AW = 17,
	parameter int DW = 64,
	parameter int DEPTH = 131070
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/bllz_walker.sv
module bllz_walker import bllz_pkg::*; #(
	parameter int CONTEXT_LEN = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  walk_req_t              req,
	input  logic [CONTEXT_LEN-1:0] hist,
	input  logic [DICT_W-1:0]      dict_limit,
	output walk_rsp_t              rsp
);

	localparam int AW = CONTEXT_LEN + 1;
	localparam int DW = 2 * COUNT_WIDTH;
	localparam int NUM_CTX = (1 << AW) - 2;
	localparam int LW = $clog2(CONTEXT_LEN + 1);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	localparam logic [1:0] W_CLEAR = 2'd0;
	localparam logic [1:0] W_IDLE = 2'd1;
	localparam logic [1:0] W_WALK = 2'd2;

	function automatic logic [AW-1:0] slot_of(input logic [LW-1:0] len,
		input logic [CONTEXT_LEN-1:0] h);
		logic [AW-1:0] one_l;
		logic [AW-1:0] low;
		one_l = AW'(1) << len;
		low = {1'b0, h} & (one_l - AW'(1));
		return one_l - AW'(2) + low;
	endfunction

	logic [1:0]             state_q;
	logic [AW-1:0]          clr_addr_q;
	logic [LW-1:0]          len_q;
	logic [CONTEXT_LEN-1:0] hist_q;
	logic                   bit_q;
	logic                   seed_q;
	logic                   vld_s1;
	logic [AW-1:0]          addr_s1;
	logic [COUNT_WIDTH-1:0] best_q;
	logic                   have_q;
	logic                   pred_q;
	logic [DICT_W-1:0]      ent_q;
	logic                   done_q;

	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic [DW-1:0]          rdata;
	logic [COUNT_WIDTH-1:0] c0;
	logic [COUNT_WIDTH-1:0] c1;
	logic [COUNT_WIDTH-1:0] cnt;
	logic [COUNT_WIDTH-1:0] mine;
	logic [COUNT_WIDTH-1:0] cnt_new;
	logic                   guess;
	logic                   found;
	logic                   room;
	logic                   upd_we;
	logic                   create;
	logic                   beat;
	logic [DW-1:0]          upd_wdata;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [DW-1:0]          wdata;

	assign rd_en = (state_q == W_WALK) && (len_q != '0);
	assign rd_addr = slot_of(len_q, hist_q);

	assign c0 = rdata[COUNT_WIDTH-1:0];
	assign c1 = rdata[DW-1:COUNT_WIDTH];
	assign guess = !(c0 > c1);
	assign cnt = guess ? c1 : c0;
	assign found = (cnt != '0);
	assign mine = bit_q ? c1 : c0;
	assign room = (ent_q < dict_limit);
	assign cnt_new = (!seed_q && found) ? ((mine == CNT_MAX) ? mine : mine + COUNT_WIDTH'(1))
		: COUNT_WIDTH'(1);
	assign upd_wdata = bit_q ? {cnt_new, c0} : {c1, cnt_new};
	assign upd_we = vld_s1 && (seed_q || found || room);
	assign create = vld_s1 && (seed_q || (!found && room));
	assign beat = vld_s1 && !seed_q && found && (cnt > best_q);

	always_comb begin
		if (state_q == W_CLEAR) begin
			we = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			we = upd_we;
			waddr = addr_s1;
			wdata = upd_wdata;
		end
	end

	bllz_count_ram #(
		.AW(AW),
		.DW(DW),
		.DEPTH(NUM_CTX)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_CLEAR;
			clr_addr_q <= '0;
			len_q <= '0;
			vld_s1 <= 1'b0;
			have_q <= 1'b0;
			pred_q <= 1'b0;
			best_q <= '0;
			ent_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == W_WALK) && (len_q == '0) && vld_s1;
			vld_s1 <= rd_en;
			if (create) begin
				ent_q <= (ent_q == ENT_MAX) ? ent_q : ent_q + DICT_W'(1);
			end
			if (beat) begin
				best_q <= cnt;
				pred_q <= guess;
				have_q <= 1'b1;
			end
			if (rd_en) begin
				len_q <= len_q - LW'(1);
			end
			unique case (state_q)
				W_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(NUM_CTX - 1)) begin
						state_q <= W_IDLE;
					end
				end
				W_IDLE: begin
					if (req.start) begin
						len_q <= LW'(CONTEXT_LEN);
						best_q <= '0;
						have_q <= 1'b0;
						pred_q <= 1'b0;
						state_q <= W_WALK;
					end
				end
				W_WALK: begin
					if (len_q == '0 && vld_s1) begin
						state_q <= W_IDLE;
					end
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == W_IDLE && req.start) begin
			hist_q <= hist;
			bit_q <= req.sample;
			seed_q <= req.seed;
		end
		addr_s1 <= rd_addr;
	end

	assign rsp.idle = (state_q == W_IDLE);
	assign rsp.done = done_q;
	assign rsp.have = have_q;
	assign rsp.pred = pred_q;

endmodule

FILE: design/bllz_score.sv
module bllz_score import bllz_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  score_upd_t       upd,
	output logic [TOT_W-1:0] nxt_correct,
	output logic [TOT_W-1:0] nxt_best,
	output logic [TOT_W-1:0] nxt_scored
);

	logic [TOT_W-1:0] correct_q;
	logic [TOT_W-1:0] run_q;
	logic [TOT_W-1:0] best_q;
	logic [TOT_W-1:0] scored_q;
	logic [TOT_W-1:0] nxt_run;

	always_comb begin
		nxt_correct = correct_q;
		nxt_run = run_q;
		nxt_best = best_q;
		nxt_scored = scored_q;
		if (upd.scored) begin
			nxt_scored = tot_inc(scored_q);
			if (upd.hit) begin
				nxt_correct = tot_inc(correct_q);
				nxt_run = tot_inc(run_q);
				if (nxt_run > best_q) begin
					nxt_best = nxt_run;
				end
			end else begin
				nxt_run = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			correct_q <= '0;
			run_q <= '0;
			best_q <= '0;
			scored_q <= '0;
		end else if (upd.load) begin
			correct_q <= nxt_correct;
			run_q <= nxt_run;
			best_q <= nxt_best;
			scored_q <= nxt_scored;
		end
	end

endmodule

FILE: design/binary_lz78y_predictor.sv
// Binary LZ78Y predictor for the prediction estimate of a noise source.
// Channel smp takes one sample bit per transfer. Channel res returns one result
// per sample: whether the position was scored, the prediction and whether it hit,
// and the running totals of correct predictions, longest correct run and scored
// positions, all saturating at 2^32-1. Channel cfg writes dict_limit: later samples
// create no context once that many exist, though seeding ignores it; cfg is always
// ready. The user must write it only while idle; the block does not enforce this.
// The first CONTEXT_LEN samples only fill the history and give a result without
// a walk. The next sample seeds the counts, and every later sample walks all
// context lengths from CONTEXT_LEN down to 1 with one read-modify-write of the
// count memory per cycle. One sample is in work at a time.
// After reset the count memory clears its 2^(CONTEXT_LEN+1) - 2 entries (131070
// at the default length) one entry per cycle; smp is not ready meanwhile.
// Results wait in an output register: a new sample is taken while a result
// waits, and its own result is held back until res accepts the old one.
module binary_lz78y_predictor import bllz_pkg::*; #(
	parameter int CONTEXT_LEN = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	bllz_smp_if.sink   smp,
	bllz_res_if.source res,
	bllz_cfg_if.sink   cfg
);

	localparam int SW = $clog2(CONTEXT_LEN + 2);

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_WALK = 2'd1;
	localparam logic [1:0] T_DONE = 2'd2;

	logic [1:0]             state_q;
	logic [CONTEXT_LEN-1:0] history_q;
	logic [SW-1:0]          bits_seen_q;
	logic [DICT_W-1:0]      dict_limit_q;
	logic                   bit_q;
	logic                   scored_q;
	logic                   out_vld_q;
	logic                   out_scored_q;
	logic                   out_have_q;
	logic                   out_pred_q;
	logic                   out_hit_q;
	logic [TOT_W-1:0]       out_correct_q;
	logic [TOT_W-1:0]       out_best_q;
	logic [TOT_W-1:0]       out_scored_tot_q;

	logic [CONTEXT_LEN:0]   hist_shift;
	logic                   accept;
	logic                   load;
	logic                   have_w;
	logic                   hit_w;
	walk_req_t              req;
	walk_rsp_t              rsp;
	score_upd_t             upd;
	logic [TOT_W-1:0]       nxt_correct;
	logic [TOT_W-1:0]       nxt_best;
	logic [TOT_W-1:0]       nxt_scored;

	assign smp.ready = (state_q == T_IDLE) && rsp.idle;
	assign accept = smp.valid && smp.ready;
	assign cfg.ready = 1'b1;
	assign hist_shift = {history_q, smp.sample_bit};

	assign req.start = accept && (bits_seen_q >= SW'(CONTEXT_LEN));
	assign req.seed = (bits_seen_q == SW'(CONTEXT_LEN));
	assign req.sample = smp.sample_bit;

	assign load = (state_q == T_DONE) && (!out_vld_q || res.ready);
	assign have_w = scored_q && rsp.have;
	assign hit_w = have_w && (rsp.pred == bit_q);

	assign upd.load = load;
	assign upd.scored = scored_q;
	assign upd.hit = hit_w;

	bllz_walker #(
		.CONTEXT_LEN(CONTEXT_LEN),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_walker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.hist(history_q),
		.dict_limit(dict_limit_q),
		.rsp(rsp)
	);

	bllz_score u_score (
		.clk(clk),
		.arst_n(arst_n),
		.upd(upd),
		.nxt_correct(nxt_correct),
		.nxt_best(nxt_best),
		.nxt_scored(nxt_scored)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			history_q <= '0;
			bits_seen_q <= '0;
			dict_limit_q <= DICT_RESET;
			out_vld_q <= 1'b0;
			out_scored_q <= 1'b0;
			out_have_q <= 1'b0;
			out_pred_q <= 1'b0;
			out_hit_q <= 1'b0;
			out_correct_q <= '0;
			out_best_q <= '0;
			out_scored_tot_q <= '0;
		end else begin
			if (cfg.valid) begin
				dict_limit_q <= cfg.dict_limit;
			end
			if (load) begin
				out_vld_q <= 1'b1;
				out_scored_q <= scored_q;
				out_have_q <= have_w;
				out_pred_q <= have_w && rsp.pred;
				out_hit_q <= hit_w;
				out_correct_q <= nxt_correct;
				out_best_q <= nxt_best;
				out_scored_tot_q <= nxt_scored;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						history_q <= hist_shift[CONTEXT_LEN-1:0];
						if (bits_seen_q <= SW'(CONTEXT_LEN)) begin
							bits_seen_q <= bits_seen_q + SW'(1);
						end
						state_q <= req.start ? T_WALK : T_DONE;
					end
				end
				T_WALK: begin
					if (rsp.done) begin
						state_q <= T_DONE;
					end
				end
				T_DONE: begin
					if (load) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bit_q <= smp.sample_bit;
			scored_q <= (bits_seen_q > SW'(CONTEXT_LEN));
		end
	end

	assign res.valid = out_vld_q;
	assign res.scored = out_scored_q;
	assign res.have_prediction = out_have_q;
	assign res.predicted_bit = out_pred_q;
	assign res.hit = out_hit_q;
	assign res.correct_total = out_correct_q;
	assign res.longest_run = out_best_q;
	assign res.scored_total = out_scored_tot_q;

	a_done_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == T_WALK)
		else $error("walker finished while no sample was in work");

	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_WALK && rsp.idle) |-> rsp.done)
		else $error("walker idle without finishing the sample");

	a_tot_order: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (nxt_scored >= nxt_correct) && (nxt_correct >= nxt_best))
		else $error("totals out of order");

	a_hit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(load && hit_w) |-> (nxt_correct != '0) && (nxt_best != '0))
		else $error("hit not counted");

endmodule

FILE: tb/lz78y_result_check.sv
`timescale 1ns / 100ps

module lz78y_result_check import bllz_pkg::*; #(
	parameter int CONTEXT_LEN = 16,
	parameter int COUNT_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	bllz_smp_if smp,
	bllz_res_if res,
	bllz_cfg_if cfg,
	output int failures,
	output int pending
);

	localparam logic [31:0] COUNT_TOP = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
	localparam int REPORT_CAP = 60;

	typedef struct packed {
		logic scored;
		logic have;
		logic pred;
		logic hit;
		logic [TOT_W-1:0] correct;
		logic [TOT_W-1:0] longest;
		logic [TOT_W-1:0] total;
	} lz_result_t;

	logic [DICT_W-1:0] dict_limit;
	logic [CONTEXT_LEN-1:0] history;
	int bits_seen;
	logic [DICT_W-1:0] entries_used;
	logic [TOT_W-1:0] correct_count;
	logic [TOT_W-1:0] current_run;
	logic [TOT_W-1:0] best_run;
	logic [TOT_W-1:0] scored_count;
	logic [31:0] pair_count [int];
	lz_result_t expected_results [$];
	int reports;

	function automatic logic [31:0] sat_up(input logic [31:0] v, input logic [31:0] top);
		return (v >= top) ? top : v + 32'd1;
	endfunction

	function automatic int slot_of(input int len);
		return (1 << len) - 2 + int'(32'(history) & ((32'd1 << len) - 32'd1));
	endfunction

	function automatic logic [31:0] count_at(input int key);
		return pair_count.exists(key) ? pair_count[key] : 32'd0;
	endfunction

	task automatic grow_entries();
		entries_used = DICT_W'(sat_up(32'(entries_used), 32'(ENT_MAX)));
	endtask

	task automatic score_bit(input logic b, output lz_result_t r);
		int len;
		int slot;
		logic [31:0] c0;
		logic [31:0] c1;
		logic [31:0] top_cnt;
		logic [31:0] best;
		logic guess;
		r = '0;
		if (bits_seen < CONTEXT_LEN) begin
			bits_seen++;
		end else if (bits_seen == CONTEXT_LEN) begin
			for (len = 1; len <= CONTEXT_LEN; len++) begin
				pair_count[2 * slot_of(len) + int'(b)] = 32'd1;
				grow_entries();
			end
			bits_seen++;
		end else begin
			best = '0;
			r.scored = 1'b1;
			for (len = CONTEXT_LEN; len >= 1; len--) begin
				slot = 2 * slot_of(len);
				c0 = count_at(slot);
				c1 = count_at(slot + 1);
				guess = !(c0 > c1);
				top_cnt = (c0 > c1) ? c0 : c1;
				if (top_cnt != 0) begin
					if (top_cnt > best) begin
						best = top_cnt;
						r.pred = guess;
						r.have = 1'b1;
					end
					pair_count[slot + int'(b)] = sat_up(count_at(slot + int'(b)), COUNT_TOP);
				end else if (entries_used < dict_limit) begin
					pair_count[slot + int'(b)] = 32'd1;
					grow_entries();
				end
			end
			scored_count = sat_up(scored_count, TOT_MAX);
			if (r.have && r.pred == b) begin
				r.hit = 1'b1;
				correct_count = sat_up(correct_count, TOT_MAX);
				current_run = sat_up(current_run, TOT_MAX);
				if (current_run > best_run) begin
					best_run = current_run;
				end
			end else begin
				current_run = '0;
			end
		end
		history = (history << 1) | CONTEXT_LEN'(b);
		r.correct = correct_count;
		r.longest = best_run;
		r.total = scored_count;
	endtask

	function automatic int field_check(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want === got) begin
			return 0;
		end
		if (reports < REPORT_CAP) begin
			$error("%s: expected %0d, got %0d", name, want, got);
		end
		reports++;
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		lz_result_t want;
		lz_result_t got;
		int errs;
		if (!arst_n) begin
			dict_limit = DICT_RESET;
			history = '0;
			bits_seen = 0;
			entries_used = '0;
			correct_count = '0;
			current_run = '0;
			best_run = '0;
			scored_count = '0;
			pair_count.delete();
			expected_results.delete();
			reports = 0;
			failures <= 0;
			pending <= 0;
		end else begin
			errs = 0;
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no sample outstanding");
					errs++;
				end else begin
					want = expected_results.pop_front();
					got = '{res.scored, res.have_prediction, res.predicted_bit, res.hit,
						res.correct_total, res.longest_run, res.scored_total};
					errs += field_check("scored", 32'(want.scored), 32'(got.scored));
					errs += field_check("have_prediction", 32'(want.have), 32'(got.have));
					errs += field_check("predicted_bit", 32'(want.pred), 32'(got.pred));
					errs += field_check("hit", 32'(want.hit), 32'(got.hit));
					errs += field_check("correct_total", want.correct, got.correct);
					errs += field_check("longest_run", want.longest, got.longest);
					errs += field_check("scored_total", want.total, got.total);
				end
			end
			if (cfg.valid && cfg.ready) begin
				dict_limit = cfg.dict_limit;
			end
			if (smp.valid && smp.ready) begin
				score_bit(smp.sample_bit, want);
				expected_results.push_back(want);
			end
			failures <= failures + errs;
			pending <= expected_results.size();
		end
	end

endmodule

FILE: tb/binary_lz78y_predictor_test.sv
`timescale 1ns / 100ps

module binary_lz78y_predictor_test import bllz_pkg::*; ();

	logic clk;
	logic arst_n;
	int failures;
	int pending;
	int gap_pct;
	int stall_pct;
	bit calm;
	bit hold_request;

	bllz_smp_if smp_ch();
	bllz_res_if res_ch();
	bllz_cfg_if cfg_ch();

	binary_lz78y_predictor dut (
		.clk(clk),
		.arst_n(arst_n),
		.smp(smp_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	lz78y_result_check result_check (
		.clk(clk),
		.arst_n(arst_n),
		.smp(smp_ch),
		.res(res_ch),
		.cfg(cfg_ch),
		.failures(failures),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_bit(input logic b);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			smp_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		smp_ch.valid <= 1'b1;
		smp_ch.sample_bit <= b;
		do @(posedge clk); while (!smp_ch.ready);
	endtask

	task automatic set_dict_limit(input logic [DICT_W-1:0] v);
		do @(posedge clk); while (pending != 0);
		cfg_ch.valid <= 1'b1;
		cfg_ch.dict_limit <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly repeating motifs and constant runs, so that long contexts recur and
	// predictions hit; the rest is plain noise.
	task automatic send_stream(input int quota);
		int sent;
		int kind;
		int span;
		int period;
		int k;
		logic [7:0] motif;
		logic level;
		sent = 0;
		while (sent < quota) begin
			if (!calm) begin
				gap_pct = 5 * $urandom_range(0, 5);
				stall_pct = 5 * $urandom_range(0, 5);
			end
			kind = $urandom_range(0, 9);
			span = (kind < 3) ? $urandom_range(1, 20) : $urandom_range(6, 40);
			period = $urandom_range(1, 8);
			motif = 8'($urandom);
			level = 1'($urandom);
			for (k = 0; k < span && sent < quota; k++) begin
				if (kind < 3) begin
					send_bit(1'($urandom));
				end else if (kind < 5) begin
					send_bit(level);
				end else begin
					send_bit(motif[k % period]);
				end
				sent++;
			end
		end
		smp_ch.valid <= 1'b0;
	endtask

	initial begin : result_sink
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				res_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_request = 1'b0;
				res_ch.ready <= 1'b1;
			end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [25:0] opening;
		int k;
		opening = {22'h3FFFFF, 4'b0110};
		arst_n = 1'b0;
		smp_ch.valid = 1'b0;
		smp_ch.sample_bit = 1'b0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.dict_limit = '0;
		gap_pct = 20;
		stall_pct = 20;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// With no room for new contexts, only the seeded all-ones contexts predict.
		set_dict_limit('0);
		for (k = 25; k >= 0; k--) begin
			send_bit(opening[k]);
		end
		smp_ch.valid <= 1'b0;

		set_dict_limit(DICT_W'(40));
		send_stream(130);
		set_dict_limit(DICT_RESET);
		send_stream(120);
		hold_request = 1'b1;
		send_stream(130);
		set_dict_limit(ENT_MAX);
		send_stream(130);
		set_dict_limit(DICT_W'(300));
		send_stream(60);
		calm = 1'b1;
		gap_pct = 0;
		stall_pct = 0;
		set_dict_limit(DICT_W'(1));
		send_stream(50);

		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
design/bllz_pkg.sv
design/bllz_if.sv
design/bllz_count_ram.sv
design/bllz_walker.sv
design/bllz_score.sv
design/binary_lz78y_predictor.sv
tb/lz78y_result_check.sv
tb/binary_lz78y_predictor_test.sv
